FILE: sv/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

  localparam int CP_W    = 21;   // code point width
  localparam int CNT_W   = 3;    // results per byte, 0..4
  localparam int LEN_W   = 3;    // expected sequence length, 0 or 2..4
  localparam int PEND_W  = 2;    // continuation bytes taken

  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  localparam logic [CP_W-1:0] MIN_TWO   = 21'h00080;
  localparam logic [CP_W-1:0] MIN_THREE = 21'h00800;
  localparam logic [CP_W-1:0] MIN_FOUR  = 21'h10000;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h0D800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h0DFFF;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

  // One byte's worth of results: count results, all bad except that the
  // final one carries cp when good_last is set.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             good_last;
    logic [CP_W-1:0]  cp;
  } usd_burst_t;

endpackage

FILE: sv/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-wide UTF-8 decoder: one scalar value per valid sequence, one bad
// result per dropped byte.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                 | tuser | tlast
//  --------+-----+-----------------------+-------+----------------------
//  s_*     | in  | [7:0] in_byte         |  -    | end_of_text
//  m_*     | out | [20:0] code_point,    | bad   | last_of_run
//          |     | [23:21] zero          |       |
//
// Intake takes one byte per cycle while the burst queue has room; each byte
// is classified in the same cycle and leaves 0 to 4 results behind.
// The output side emits one result per cycle while m_tready holds, so a byte
// that drops a broken sequence takes one output slot per result (up to 4).
// Output stalls back up into the QUEUE_DEPTH-entry queue before s_tready drops.
// Reset (synchronous, rst high) closes any open sequence and empties the
// queue and the output register.
//
module utf8_stream_decoder
  import usd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // request in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_text
  // result out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tuser,   // [0] bad
  output logic        m_tlast    // last_of_run
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  usd_burst_t      burst;
  usd_burst_t      head;
  logic [CP_W-1:0] code_point;

  // Room in the queue is all the front needs; a byte is held off only while
  // the queue is full.
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  usd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (s_tdata),
    .end_of_text (s_tlast),
    .push        (push),
    .burst       (burst)
  );

  usd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (burst),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  usd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .code_point  (code_point),
    .bad         (m_tuser),
    .last_of_run (m_tlast)
  );

  assign m_tdata = {3'd0, code_point};

endmodule

FILE: sv/usd_front.sv
// ----------------------------------------------------------------------------
// usd_front
// Byte intake: tracks the open sequence and classifies each byte into a
// burst of results.
// ----------------------------------------------------------------------------
module usd_front
  import usd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       push,
  output usd_burst_t burst
);

  logic [LEN_W-1:0]  exp_len, exp_len_next;
  logic [PEND_W-1:0] pend, pend_next;
  logic [CP_W-1:0]   partial, partial_next;

  always_comb begin
    logic             is_cont;
    logic             open_seq;
    logic [CNT_W-1:0] n_bad;
    logic             f_out;     // fresh decode yields a result
    logic             f_good;
    logic [CP_W-1:0]  f_cp;
    logic             f_open;
    logic [LEN_W-1:0] f_len;
    logic [CP_W-1:0]  f_bits;
    logic             do_fresh;
    logic [CP_W-1:0]  cp;
    logic [CP_W-1:0]  minimum;
    logic [PEND_W:0]  taken;
    logic             invalid;

    is_cont  = (in_byte[7:6] == 2'b10);
    open_seq = (exp_len == LEN_TWO) || (exp_len == LEN_THREE) || (exp_len == LEN_FOUR);
    n_bad    = '0;
    do_fresh = 1'b0;
    burst.good_last = 1'b0;
    burst.cp        = '0;
    exp_len_next = exp_len;
    pend_next    = pend;
    partial_next = partial;

    // fresh decode of this byte
    f_out  = 1'b0;
    f_good = 1'b0;
    f_cp   = '0;
    f_open = 1'b0;
    f_len  = LEN_NONE;
    f_bits = '0;
    if (!in_byte[7]) begin
      f_out  = 1'b1;
      f_good = 1'b1;
      f_cp   = {13'd0, in_byte};
    end else if (in_byte[7:5] == 3'b110) begin
      f_len  = LEN_TWO;
      f_bits = {16'd0, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      f_len  = LEN_THREE;
      f_bits = {17'd0, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      f_len  = LEN_FOUR;
      f_bits = {18'd0, in_byte[2:0]};
    end else begin
      f_out = 1'b1;
    end
    if (f_len != LEN_NONE) begin
      if (end_of_text) f_out = 1'b1;   // lead truncated by end of text
      else f_open = 1'b1;
    end

    // continuation path
    cp    = {partial[CP_W-7:0], in_byte[5:0]};
    taken = {1'b0, pend} + 3'd1;
    case (exp_len)
      LEN_TWO:   minimum = MIN_TWO;
      LEN_THREE: minimum = MIN_THREE;
      default:   minimum = MIN_FOUR;
    endcase
    invalid = (cp < minimum) || ((cp >= SURR_LO) && (cp <= SURR_HI)) || (cp > CP_MAX);

    if (!open_seq) begin
      do_fresh = 1'b1;
    end else if (is_cont) begin
      if (taken >= exp_len - 3'd1) begin
        if (invalid) begin
          n_bad = exp_len;
        end else begin
          n_bad           = 3'd1;
          burst.good_last = 1'b1;
          burst.cp        = cp;
        end
        exp_len_next = LEN_NONE;
        pend_next    = '0;
        partial_next = '0;
      end else if (end_of_text) begin
        n_bad = taken + 3'd1;
      end else begin
        pend_next    = taken[PEND_W-1:0];
        partial_next = cp;
      end
    end else begin
      // sequence broken: flush lead and continuations, then decode afresh
      n_bad    = taken;
      do_fresh = 1'b1;
    end

    if (do_fresh) begin
      exp_len_next = f_open ? f_len : LEN_NONE;
      pend_next    = '0;
      partial_next = f_open ? f_bits : '0;
      if (f_out) begin
        n_bad           = n_bad + 3'd1;
        burst.good_last = f_good;
        burst.cp        = f_cp;
      end
    end

    if (end_of_text) begin
      exp_len_next = LEN_NONE;
      pend_next    = '0;
      partial_next = '0;
    end

    burst.count = n_bad;
    push        = accept && (n_bad != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= LEN_NONE;
      pend    <= '0;
      partial <= '0;
    end else if (accept) begin
      exp_len <= exp_len_next;
      pend    <= pend_next;
      partial <= partial_next;
    end
  end

endmodule

FILE: sv/usd_queue.sv
// ----------------------------------------------------------------------------
// usd_queue
// Small register FIFO of result bursts between intake and output.
// ----------------------------------------------------------------------------
module usd_queue
  import usd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  usd_burst_t push_data,
  input  logic       pop,
  output usd_burst_t head,
  output logic       full,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  usd_burst_t        slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [FILL_W-1:0] fill;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (fill == FILL_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      case ({push, pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: sv/usd_back.sv
// ----------------------------------------------------------------------------
// usd_back
// Expands each queued burst into single results through an output register.
// ----------------------------------------------------------------------------
module usd_back
  import usd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  usd_burst_t      head,
  input  logic            empty,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [CP_W-1:0] code_point,
  output logic            bad,
  output logic            last_of_run
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;

  assign load    = !empty && (!m_tvalid || m_tready);
  assign is_last = ({1'b0, idx} == head.count - 3'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= is_last ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_of_run <= is_last;
      bad         <= !(is_last && head.good_last);
      code_point  <= (is_last && head.good_last) ? head.cp : '0;
    end
  end

endmodule

FILE: tb/tb_utf8_stream_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder
// Self-checking bench for the byte-wide UTF-8 decoder. A behavioral decoder
// predicts the scalar values and dropped-byte results of every accepted
// request. Each returned result is checked in order against that
// prediction. Stimulus is a directed list of corner sequences, then random
// text: mostly well-formed characters mixed with overlong, surrogate,
// out-of-range, cut-off and stray bytes. The random text runs under several
// sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;
  import usd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASE_BYTES    = 40;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            bad;
    logic            last;
  } scalar_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // behavioral decoder state
  logic [LEN_W-1:0]  open_len    = LEN_NONE;
  logic [PEND_W-1:0] cont_count  = '0;
  logic [CP_W-1:0]   gathered_cp = '0;

  scalar_result_t byte_results[$];     // results of the byte being decoded
  scalar_result_t pending_results[$];  // predicted, not yet returned

  int mismatch_count = 0;
  int bytes_sent     = 0;
  int quiet_cycles   = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  utf8_stream_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  task automatic emit(input logic [CP_W-1:0] cp, input logic bad);
    scalar_result_t entry;
    entry        = '{cp, bad, 1'b0};
    byte_results = {byte_results, entry};
  endtask

  // one bad result per dropped byte
  task automatic emit_drops(input int count);
    repeat (count) emit('0, 1'b1);
  endtask

  task automatic close_sequence();
    open_len    = LEN_NONE;
    cont_count  = '0;
    gathered_cp = '0;
  endtask

  // byte seen with no sequence open: ASCII, a lead, a stray continuation or a bad lead
  task automatic decode_fresh(input logic [7:0] b, input logic eot);
    logic [LEN_W-1:0] lead_len;
    logic [CP_W-1:0]  lead_bits;
    lead_len  = LEN_NONE;
    lead_bits = '0;
    if (b[7] == 1'b0) begin
      emit(CP_W'(b), 1'b0);
      return;
    end
    if (b[7:5] == 3'b110) begin
      lead_len  = LEN_TWO;
      lead_bits = CP_W'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      lead_len  = LEN_THREE;
      lead_bits = CP_W'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      lead_len  = LEN_FOUR;
      lead_bits = CP_W'(b[2:0]);
    end
    if (lead_len == LEN_NONE || eot) begin
      // stray continuation, F8..FF, or a lead cut off by end of text
      emit_drops(1);
      return;
    end
    open_len    = lead_len;
    cont_count  = '0;
    gathered_cp = lead_bits;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    int              taken;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] floor_cp;
    byte_results.delete();
    if (open_len == LEN_NONE) begin
      close_sequence();
      decode_fresh(b, eot);
    end else if (b[7:6] == 2'b10) begin
      taken = int'(cont_count) + 1;
      cp    = {gathered_cp[CP_W-7:0], b[5:0]};
      if (taken >= int'(open_len) - 1) begin
        case (open_len)
          LEN_TWO:   floor_cp = MIN_TWO;
          LEN_THREE: floor_cp = MIN_THREE;
          default:   floor_cp = MIN_FOUR;
        endcase
        // overlong, surrogate or past the top: every byte is dropped
        if (cp < floor_cp || (cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX) begin
          emit_drops(int'(open_len));
        end else begin
          emit(cp, 1'b0);
        end
        close_sequence();
      end else if (eot) begin
        // truncated: lead plus every continuation taken, this one included
        emit_drops(taken + 1);
        close_sequence();
      end else begin
        cont_count  = PEND_W'(taken);
        gathered_cp = cp;
      end
    end else begin
      // broken sequence; the breaking byte is decoded on its own
      emit_drops(int'(cont_count) + 1);
      close_sequence();
      decode_fresh(b, eot);
    end
    if (eot) close_sequence();
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) pending_results = {pending_results, byte_results[i]};
  endtask

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: mismatch on %s, expected %h, got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // predict on every accepted request, check every accepted result
  always @(posedge clk) begin
    scalar_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 32'h0, 32'({m_tlast, m_tuser, m_tdata}));
        end else begin
          want = pending_results.pop_front();
          if (m_tdata !== {{(24 - CP_W){1'b0}}, want.cp})
            report_mismatch("code_point", 32'(want.cp), 32'(m_tdata));
          if (m_tuser !== want.bad)
            report_mismatch("bad", 32'(want.bad), 32'(m_tuser));
          if (m_tlast !== want.last)
            report_mismatch("last_of_run", 32'(want.last), 32'(m_tlast));
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_utf8_stream_decoder failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------ driving

  // present one request, with random gaps ahead of it, and hold until taken
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int gap_pct, input int stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
  endtask

  // send the first keep bytes of the raw len-byte encoding of cp; no range
  // check, so overlong and past-the-top values can be built
  task automatic send_encoded(input logic [CP_W-1:0] cp, input int len, input int keep,
                              input logic eot_last);
    logic [7:0] seq [4];
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) send_byte(seq[i], eot_last && (i == keep - 1));
  endtask

  function automatic logic [CP_W-1:0] pick_scalar(input int len);
    case (len)
      1: return CP_W'($urandom_range(32'h7F));
      2: return CP_W'($urandom_range(32'h7FF, 32'h80));
      3: begin
        if ($urandom_range(1) == 0) return CP_W'($urandom_range(32'hD7FF, 32'h800));
        return CP_W'($urandom_range(32'hFFFF, 32'hE000));
      end
      default: return CP_W'($urandom_range(32'h10FFFF, 32'h10000));
    endcase
  endfunction

  // -------------------------------------------------------------------- tests

  task automatic test_directed_cases();
    send_byte(8'h00, 1'b0);                           // lowest ASCII
    send_byte(8'h7F, 1'b1);                           // highest ASCII, end of text
    send_encoded(CP_W'(32'h80), 2, 2, 1'b0);          // smallest two-byte value
    send_encoded(CP_W'(32'h10FFFF), 4, 4, 1'b0);      // top scalar value
    send_encoded(CP_W'(32'hD800), 3, 3, 1'b0);        // surrogate
    send_encoded(CP_W'(32'h110000), 4, 4, 1'b0);      // past the top
    send_encoded(CP_W'(32'h00), 2, 2, 1'b0);          // overlong NUL
    send_byte(8'hFF, 1'b0);                           // never a lead
    send_encoded(CP_W'(32'h800), 3, 2, 1'b0);         // cut off by ASCII ...
    send_byte(8'h41, 1'b1);                           // ... which also ends text
    send_byte(8'hF0, 1'b1);                           // lead on the final byte
    send_encoded(CP_W'(32'h1000), 3, 2, 1'b1);        // truncated by end of text
    send_byte(8'h80, 1'b0);                           // stray continuation
  endtask

  task automatic test_random_text(input int count);
    int              stop;
    int              pick;
    int              len;
    logic [CP_W-1:0] cp;
    logic [7:0]      brk;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      pick = $urandom_range(99);
      len  = $urandom_range(4, 1);
      if (pick < 55) begin
        send_encoded(pick_scalar(len), len, len, $urandom_range(9) == 0);
      end else if (pick < 65) begin
        // complete sequence with a value it may not carry
        case ($urandom_range(2))
          0: begin
            len = $urandom_range(4, 2);
            cp  = CP_W'($urandom_range(len == 2 ? 32'h7F : (len == 3 ? 32'h7FF : 32'hFFFF)));
          end
          1: begin
            len = 3;
            cp  = CP_W'($urandom_range(32'hDFFF, 32'hD800));
          end
          default: begin
            len = 4;
            cp  = CP_W'($urandom_range(32'h1FFFFF, 32'h110000));
          end
        endcase
        send_encoded(cp, len, len, $urandom_range(9) == 0);
      end else if (pick < 75) begin
        // open sequence broken by a byte that is not a continuation
        len = $urandom_range(4, 2);
        send_encoded(pick_scalar(len), len, $urandom_range(len - 1, 1), 1'b0);
        brk = 8'($urandom_range(255));
        if (brk[7:6] == 2'b10) brk[6] = 1'b1;
        send_byte(brk, $urandom_range(9) == 0);
      end else if (pick < 90) begin
        send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
      end else begin
        // sequence cut short by end of text
        len = $urandom_range(4, 2);
        send_encoded(pick_scalar(len), len, $urandom_range(len - 1, 1), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(0, 0);
    test_directed_cases();
    wait_drained();

    set_idling(0, 0);
    test_random_text(PHASE_BYTES);
    wait_drained();

    set_idling(53, 0);
    test_random_text(PHASE_BYTES);
    wait_drained();

    set_idling(0, 53);
    test_random_text(PHASE_BYTES);
    wait_drained();

    set_idling(13, 13);
    test_random_text(PHASE_BYTES);
    wait_drained();

    if (pending_results.size() != 0)
      report_mismatch("results never returned", 32'h0, 32'(pending_results.size()));
    if (mismatch_count == 0) begin
      $display("tb_utf8_stream_decoder passed");
    end else begin
      $display("tb_utf8_stream_decoder failed");
    end
    $finish;
  end

endmodule
